[hw/rtl/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front disk stack.
// ----------------------------------------------------------------------------
package mtf_pkg;

   // stack geometry
   localparam int DEPTH       = 64;
   localparam int DEPTH_W     = $clog2(DEPTH);

   // field widths
   localparam int DISK_W      = 7;
   localparam int POS_W       = 6;
   localparam int PRIOR_W     = 6;

   // disk count after reset
   localparam logic [DISK_W-1:0] DISK_COUNT_RESET = DISK_W'(64);

   // opcodes
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // request word
   typedef struct packed {
      logic              opcode;
      logic [DISK_W-1:0] disk;
      logic [POS_W-1:0]  position;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [PRIOR_W-1:0] prior_depth;
      logic [DISK_W-1:0]  entry_value;
      logic               invalid;
   } rsp_word_type;

   // per-cell control
   typedef struct packed {
      logic refill;
      logic shift;
   } cell_ctrl_type;

endpackage

[hw/rtl/move_to_front_stack.sv]
// ----------------------------------------------------------------------------
// move_to_front_stack
// Move-to-front stack of disk numbers built from a row of compare cells.
// ----------------------------------------------------------------------------
// Takes one word per clock: busy never rises, and each word's response
// appears on rsp_word with rsp_valid high in the cycle after start was
// sampled. rsp_valid is high for that one cycle only and the receiver cannot
// hold it off, so each response must be taken in the cycle it appears.
// An access word compares the disk with every stack place at once; the hit
// place and the places above it take their upper neighbour's entry and the
// top takes the disk, so the whole move is done in the cycle the word is
// taken. A read word selects one place. A write of csr_wdata refills the
// stack with 1..count in the same cycle (counts above the stack depth are
// clipped) and should only be issued while no response is pending.
// ----------------------------------------------------------------------------
module move_to_front_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mtf_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   output mtf_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_wen,
   input  logic [mtf_pkg::DISK_W-1:0]    csr_wdata
);
   import mtf_pkg::*;

   logic                  accept;
   logic [DISK_W-1:0]     count_ff;
   logic [DISK_W-1:0]     count_in;
   logic [DISK_W-1:0]     fill_count;
   logic [DISK_W-1:0]     entries [DEPTH];
   logic [DEPTH-1:0]      match_vec;
   logic [DEPTH-1:0]      hit_vec;
   logic [DEPTH-1:0]      shift_vec;
   logic                  hit_any;
   logic                  do_access;
   logic [PRIOR_W-1:0]    hit_depth;
   logic [DISK_W-1:0]     read_value;
   logic                  pos_ok;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;
   rsp_word_type          rsp_word_in;

   // busy is tied low, so the request side never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // count in use, clipped to the stack depth
   always_comb begin
      fill_count = csr_wdata;
      if (int'(csr_wdata) > DEPTH) begin
         fill_count = DISK_W'(DEPTH);
      end
      if (reset) begin
         fill_count = DISK_COUNT_RESET;
         if (int'(DISK_COUNT_RESET) > DEPTH) begin
            fill_count = DISK_W'(DEPTH);
         end
      end
      count_in = count_ff;
      if (reset || csr_wen) begin
         count_in = fill_count;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   // a hit needs a non-zero disk, empty places hold zero
   assign do_access = accept && (req_word.opcode == OP_ACCESS);
   assign hit_vec   = (req_word.disk != '0) ? match_vec : '0;
   assign hit_any   = |hit_vec;

   // a place shifts when the hit lies at or below it
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         shift_vec[k] = do_access && |(hit_vec >> k);
      end
   end

   // row of cells, each fed by its upper neighbour, the top by the disk
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [DISK_W-1:0] fill_value;
      logic [DISK_W-1:0] upper_value;

      assign ctrl.refill = reset || csr_wen;
      assign ctrl.shift  = shift_vec[i];
      assign fill_value  = (i < int'(fill_count)) ? DISK_W'(i + 1) : '0;

      if (i == 0) begin : g_top
         assign upper_value = req_word.disk;
      end else begin : g_rest
         assign upper_value = entries[i-1];
      end

      mtf_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .fill_value  (fill_value),
         .upper_value (upper_value),
         .probe_disk  (req_word.disk),
         .entry       (entries[i]),
         .match       (match_vec[i])
      );
   end

   // depth of the hit, at most one place matches
   always_comb begin
      hit_depth = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit_vec[i]) begin
            hit_depth = hit_depth | PRIOR_W'(i);
         end
      end
   end

   // read selection
   always_comb begin
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (i == int'(req_word.position)) begin
            read_value = entries[i];
         end
      end
   end

   assign pos_ok = int'(req_word.position) < int'(count_ff);

   // response word
   always_comb begin
      rsp_word_in = '0;
      if (req_word.opcode == OP_ACCESS) begin
         rsp_word_in.invalid = !hit_any;
         if (hit_any) begin
            rsp_word_in.prior_depth = hit_depth;
         end
      end else begin
         rsp_word_in.invalid = !pos_ok;
         if (pos_ok) begin
            rsp_word_in.entry_value = read_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // every accepted word gives a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after accepted word");

   // disks in the stack are distinct
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> $onehot0(hit_vec))
      else $error("disk found at more than one place");

   // an invalid response reports depth zero
   a_invalid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.invalid |-> rsp_word.prior_depth == '0)
      else $error("invalid response with non-zero depth");

   // a refill puts disk one on top when the count is non-zero
   a_refill_top: assert property (@(posedge clock) disable iff (reset)
      csr_wen && (csr_wdata != '0) |=> entries[0] == DISK_W'(1))
      else $error("refill left wrong top entry");
`endif

endmodule

[hw/rtl/mtf_cell.sv]
// ----------------------------------------------------------------------------
// mtf_cell
// One stack place: holds a disk number, compares it with the broadcast disk
// and takes its upper neighbour's entry when the stack shifts down.
// ----------------------------------------------------------------------------
module mtf_cell (
   input  logic                          clock,
   input  mtf_pkg::cell_ctrl_type        ctrl,
   input  logic [mtf_pkg::DISK_W-1:0]    fill_value,
   input  logic [mtf_pkg::DISK_W-1:0]    upper_value,
   input  logic [mtf_pkg::DISK_W-1:0]    probe_disk,
   output logic [mtf_pkg::DISK_W-1:0]    entry,
   output logic                          match
);
   import mtf_pkg::*;

   logic [DISK_W-1:0] entry_ff;
   logic [DISK_W-1:0] entry_in;

   // refill wins over a shift
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.refill) begin
         entry_in = fill_value;
      end else if (ctrl.shift) begin
         entry_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // compare with the broadcast disk
   assign match = (entry_ff == probe_disk);
   assign entry = entry_ff;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the move-to-front disk stack. Words go in through
// the start/busy command port with random gaps between them. A local model of
// the stack predicts each response, and every response is checked field by
// field against the oldest prediction. The disk count register is rewritten
// between phases, including zero, one and a value above the stack depth.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtf_pkg::*;

   // idle cycles let pass before a count write once the responses are in
   localparam int SETTLE_CYCLES  = 3;
   // cycles with no word moving in either direction before giving up
   localparam int WATCHDOG_LIMIT = 400;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_WORDS    = 85;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_word_type        req_word  = '0;
   logic                rsp_valid;
   rsp_word_type        rsp_word;
   logic                csr_wen   = 1'b0;
   logic [DISK_W-1:0]   csr_wdata = '0;

   // local copy of the stack and the count in use
   logic [DISK_W-1:0]   stack_model [DEPTH];
   int unsigned         model_count;

   rsp_word_type        pending_rsp [$];
   rsp_word_type        oldest_rsp;
   int unsigned         error_count = 0;
   int unsigned         idle_cycles = 0;

   move_to_front_stack dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // refill the model stack with 1..count from the top down
   function automatic void refill_stack(logic [DISK_W-1:0] count_value);
      model_count = (count_value > DEPTH) ? DEPTH : count_value;
      for (int i = 0; i < DEPTH; i++) begin
         stack_model[i] = (i < model_count) ? DISK_W'(i + 1) : '0;
      end
   endfunction

   // expected response for one word, moving the disk to the top on an access
   function automatic rsp_word_type mtf_predict(req_word_type w);
      rsp_word_type r;
      int unsigned  hit;
      r = '0;
      if (w.opcode == OP_ACCESS) begin
         if (w.disk == 0 || w.disk > model_count) begin
            r.invalid = 1'b1;
         end else begin
            hit = 0;
            while (hit < model_count && stack_model[hit] != w.disk) hit++;
            if (hit >= model_count) begin
               r.invalid = 1'b1;
            end else begin
               for (int k = hit; k > 0; k--) stack_model[k] = stack_model[k-1];
               stack_model[0] = w.disk;
               r.prior_depth  = PRIOR_W'(hit);
            end
         end
      end else if (w.position < model_count) begin
         r.entry_value = stack_model[w.position];
      end else begin
         r.invalid = 1'b1;
      end
      return r;
   endfunction

   function automatic req_word_type make_req(logic op, int unsigned disk, int unsigned pos);
      req_word_type w;
      w.opcode   = op;
      w.disk     = DISK_W'(disk);
      w.position = POS_W'(pos);
      return w;
   endfunction

   // mostly well-formed accesses and reads, some noise in the disk and position fields
   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      int unsigned  near_top;
      pick       = $urandom_range(0, 99);
      w.opcode   = (pick < 60) ? OP_ACCESS : OP_READ;
      w.disk     = DISK_W'($urandom());
      w.position = POS_W'($urandom());
      if (model_count > 0) begin
         if (pick < 20) begin
            // disks near the top, so repeats are frequent
            near_top = (model_count > 4) ? 3 : model_count - 1;
            w.disk   = stack_model[$urandom_range(0, near_top)];
         end else if (pick < 52) begin
            w.disk = DISK_W'($urandom_range(1, model_count));
         end else if (pick >= 60 && pick < 92) begin
            w.position = POS_W'($urandom_range(0, model_count - 1));
         end
      end
      return w;
   endfunction

   // send one word after a gap, leaving start high for a following word
   task automatic send_word(req_word_type w, int unsigned gap);
      logic stalled;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
      pending_rsp.push_back(mtf_predict(w));
   endtask

   // stop sending and wait until every expected response has come
   task automatic wait_drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_disk_count(logic [DISK_W-1:0] value);
      wait_drain();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      refill_stack(value);
   endtask

   // stack order after reset, bottom disk, repeats and out-of-range disks
   task automatic test_reset_order();
      send_word(make_req(OP_READ,   0,   0), 0);
      send_word(make_req(OP_READ,   0,  63), 0);
      send_word(make_req(OP_ACCESS, 64,  0), $urandom_range(0, 19));
      send_word(make_req(OP_READ,   0,   0), 0);
      send_word(make_req(OP_READ,   0,  63), $urandom_range(0, 19));
      send_word(make_req(OP_ACCESS, 64, 63), 0);
      send_word(make_req(OP_ACCESS, 1,   0), 0);
      send_word(make_req(OP_ACCESS, 0,  63), $urandom_range(0, 19));
      send_word(make_req(OP_ACCESS, 65,  0), 0);
      send_word(make_req(OP_ACCESS, 127, 0), 0);
      send_word(make_req(OP_READ,   127, 1), $urandom_range(0, 19));
   endtask

   // empty stack, single disk and a count above the stack depth
   task automatic test_count_extremes();
      set_disk_count(DISK_W'(0));
      send_word(make_req(OP_ACCESS, 1, 0), 0);
      send_word(make_req(OP_READ,   0, 0), 0);
      set_disk_count(DISK_W'(1));
      send_word(make_req(OP_ACCESS, 1, 0), 0);
      send_word(make_req(OP_ACCESS, 1, 0), $urandom_range(0, 19));
      send_word(make_req(OP_READ,   0, 0), 0);
      send_word(make_req(OP_READ,   0, 1), 0);
      send_word(make_req(OP_ACCESS, 2, 0), 0);
      set_disk_count(DISK_W'(127));
      send_word(make_req(OP_ACCESS, 64, 0), 0);
      send_word(make_req(OP_READ,   0, 63), $urandom_range(0, 19));
      send_word(make_req(OP_ACCESS, 65, 0), 0);
   endtask

   // random traffic over several counts, with bursts and a mid-phase drain
   task automatic test_random_traffic();
      logic [DISK_W-1:0] counts [PHASE_COUNT];
      logic              burst;
      counts = '{DISK_W'(64), DISK_W'(5), DISK_W'(2), DISK_W'(127),
                 DISK_W'(0), DISK_W'(63), DISK_W'(65), DISK_W'(0)};
      counts[4] = DISK_W'($urandom_range(3, 62));
      counts[7] = DISK_W'($urandom_range(1, 127));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_disk_count(counts[p]);
         burst = (p % 3 == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2) wait_drain();
            send_word(random_word(), burst ? 0 : $urandom_range(0, 19));
         end
      end
   endtask

   // compare each response with the oldest prediction
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none expected: %p", rsp_word);
            error_count++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_word.prior_depth !== oldest_rsp.prior_depth) begin
               $error("prior_depth expected %0d got %0d",
                      oldest_rsp.prior_depth, rsp_word.prior_depth);
               error_count++;
            end
            if (rsp_word.entry_value !== oldest_rsp.entry_value) begin
               $error("entry_value expected %0d got %0d",
                      oldest_rsp.entry_value, rsp_word.entry_value);
               error_count++;
            end
            if (rsp_word.invalid !== oldest_rsp.invalid) begin
               $error("invalid expected %0b got %0b",
                      oldest_rsp.invalid, rsp_word.invalid);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles where no word is taken or returned
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      refill_stack(DISK_COUNT_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_order();
      test_count_extremes();
      test_random_traffic();
      wait_drain();
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
